>>> rtl/core/cfrm_pkg.sv
// Shared types and constants for the charger fault remediation monitor.
// Used by every design module of the block (not by cfrm_checker); depends on nothing else.

package cfrm_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_COOLDOWN    = 3'd0,
        REG_STUCK_LIMIT = 3'd1,
        REG_SOC_TOL     = 3'd2,
        REG_OFF_LOW     = 3'd3,
        REG_OFF_HIGH    = 3'd4,
        REG_ON_LOW      = 3'd5,
        REG_ON_HIGH     = 3'd6
    } reg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned OUT_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [31:0]        COOLDOWN_RST    = 32'd3600000;
    localparam logic [31:0]        STUCK_LIMIT_RST = 32'd21600000;
    localparam logic [13:0]        SOC_TOL_RST     = 14'd100;
    localparam logic signed [11:0] OFF_LOW_RST     = 12'sd0;
    localparam logic signed [11:0] OFF_HIGH_RST    = 12'sd450;
    localparam logic signed [11:0] ON_LOW_RST      = 12'sd20;
    localparam logic signed [11:0] ON_HIGH_RST     = 12'sd430;

    // Charge fault codes (fault byte bits 5..3).
    localparam logic [2:0] FCODE_NONE    = 3'd0;
    localparam logic [2:0] FCODE_INPUT   = 3'd1;
    localparam logic [2:0] FCODE_THERMAL = 3'd2;
    localparam logic [2:0] FCODE_TIMER   = 3'd3;

    // Alert codes reported on the result word.
    localparam logic [1:0] ALERT_NONE    = 2'd0;
    localparam logic [1:0] ALERT_THERMAL = 2'd1;
    localparam logic [1:0] ALERT_TIMEOUT = 2'd2;
    localparam logic [1:0] ALERT_BATTERY = 2'd3;

    // Remediation levels and the actions they emit share one encoding.
    localparam logic [1:0] REMEDY_NONE     = 2'd0;
    localparam logic [1:0] REMEDY_CYCLE    = 2'd1;
    localparam logic [1:0] REMEDY_WATCHDOG = 2'd2;

    localparam logic [1:0] CSTAT_FAST = 2'd2;

    localparam logic [7:0] STREAK_MAX   = 8'd255;
    localparam logic [7:0] STREAK_LVL1  = 8'd2;
    localparam logic [7:0] STREAK_LVL2  = 8'd3;

    // Held PMIC alert codes that a clean poll ending a fault streak clears.
    localparam logic signed [7:0] PMIC_ALERT_LO = 8'sd20;
    localparam logic signed [7:0] PMIC_ALERT_HI = 8'sd23;

    typedef struct packed {
        logic [31:0]        cooldown_ms;
        logic [31:0]        stuck_limit_ms;
        logic [13:0]        soc_tolerance;
        logic signed [11:0] off_low_temp;
        logic signed [11:0] off_high_temp;
        logic signed [11:0] on_low_temp;
        logic signed [11:0] on_high_temp;
    } cfg_t;

    typedef struct packed {
        logic signed [7:0]  active_alert;
        logic [31:0]        now_ms;
        logic signed [11:0] temperature;
        logic [13:0]        charge_level;
        logic [7:0]         status_byte;
        logic [7:0]         fault_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] fault_run;
        logic       clear_alert;
        logic       charge_allowed;
        logic [1:0] remedy_action;
        logic       stuck_alert;
        logic [1:0] fault_alert;
    } result_t;

endpackage

>>> rtl/core/cfrm_cfg_regs.sv
// Configuration register file of the charger fault remediation monitor.
// Depends on cfrm_pkg for the register indexes, reset values and cfg_t.

module cfrm_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [cfrm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cfrm_pkg::CFG_DATA_W-1:0] wr_data,
    output cfrm_pkg::cfg_t                  cfg
);

    cfrm_pkg::cfg_t cfg_reg;
    cfrm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfrm_pkg::reg_idx_t'(wr_index))
                cfrm_pkg::REG_COOLDOWN:    cfg_next.cooldown_ms    = wr_data;
                cfrm_pkg::REG_STUCK_LIMIT: cfg_next.stuck_limit_ms = wr_data;
                cfrm_pkg::REG_SOC_TOL:     cfg_next.soc_tolerance  = wr_data[13:0];
                cfrm_pkg::REG_OFF_LOW:     cfg_next.off_low_temp   = wr_data[11:0];
                cfrm_pkg::REG_OFF_HIGH:    cfg_next.off_high_temp  = wr_data[11:0];
                cfrm_pkg::REG_ON_LOW:      cfg_next.on_low_temp    = wr_data[11:0];
                cfrm_pkg::REG_ON_HIGH:     cfg_next.on_high_temp   = wr_data[11:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cooldown_ms    <= cfrm_pkg::COOLDOWN_RST;
            cfg_reg.stuck_limit_ms <= cfrm_pkg::STUCK_LIMIT_RST;
            cfg_reg.soc_tolerance  <= cfrm_pkg::SOC_TOL_RST;
            cfg_reg.off_low_temp   <= cfrm_pkg::OFF_LOW_RST;
            cfg_reg.off_high_temp  <= cfrm_pkg::OFF_HIGH_RST;
            cfg_reg.on_low_temp    <= cfrm_pkg::ON_LOW_RST;
            cfg_reg.on_high_temp   <= cfrm_pkg::ON_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/cfrm_core.sv
// Per-poll decision logic and the monitor state it carries between polls.
// Depends on cfrm_pkg for item_t, result_t, cfg_t and the code constants.

module cfrm_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  cfrm_pkg::item_t   item,
    input  cfrm_pkg::cfg_t    cfg,
    output cfrm_pkg::result_t result
);

    logic        safe_reg,         safe_next;
    logic [7:0]  streak_reg,       streak_next;
    logic [1:0]  level_reg,        level_next;
    logic [31:0] last_remedy_reg,  last_remedy_next;
    logic        prev_fast_reg,    prev_fast_next;
    logic [13:0] prev_level_reg,   prev_level_next;
    logic [31:0] stuck_start_reg,  stuck_start_next;

    always_comb begin
        logic        safe;
        logic [2:0]  code;
        logic [31:0] cool_elapsed;
        logic [31:0] stuck_elapsed;
        logic [1:0]  lvl;
        logic [1:0]  cstat;
        logic [13:0] diff;

        safe_next        = safe_reg;
        streak_next      = streak_reg;
        level_next       = level_reg;
        last_remedy_next = last_remedy_reg;
        stuck_start_next = stuck_start_reg;
        result           = '0;

        // Hysteresis: the wide window holds charging on, the narrow one grants it again.
        if (safe_reg) begin
            safe = !((item.temperature < cfg.off_low_temp) ||
                     (item.temperature > cfg.off_high_temp));
        end else begin
            safe = !((item.temperature < cfg.on_low_temp) ||
                     (item.temperature > cfg.on_high_temp));
        end
        safe_next             = safe;
        result.charge_allowed = safe;

        code         = item.fault_byte[5:3];
        cool_elapsed = item.now_ms - last_remedy_reg;
        lvl          = level_reg;

        if (code != cfrm_pkg::FCODE_NONE) begin
            if (streak_reg != cfrm_pkg::STREAK_MAX) begin
                streak_next = streak_reg + 8'd1;
            end
            case (code)
                cfrm_pkg::FCODE_INPUT:   result.fault_alert = cfrm_pkg::ALERT_NONE;
                cfrm_pkg::FCODE_THERMAL: result.fault_alert = cfrm_pkg::ALERT_THERMAL;
                cfrm_pkg::FCODE_TIMER:   result.fault_alert = cfrm_pkg::ALERT_TIMEOUT;
                default:                 result.fault_alert = cfrm_pkg::ALERT_BATTERY;
            endcase

            if (safe && (cool_elapsed > cfg.cooldown_ms)) begin
                if ((streak_next >= cfrm_pkg::STREAK_LVL2) &&
                    (lvl < cfrm_pkg::REMEDY_WATCHDOG)) begin
                    lvl = cfrm_pkg::REMEDY_WATCHDOG;
                end else if ((streak_next >= cfrm_pkg::STREAK_LVL1) &&
                             (lvl < cfrm_pkg::REMEDY_CYCLE)) begin
                    lvl = cfrm_pkg::REMEDY_CYCLE;
                end
                // The watchdog step is the top of the ladder and starts it over.
                if (lvl == cfrm_pkg::REMEDY_CYCLE) begin
                    result.remedy_action = cfrm_pkg::REMEDY_CYCLE;
                end else if (lvl == cfrm_pkg::REMEDY_WATCHDOG) begin
                    result.remedy_action = cfrm_pkg::REMEDY_WATCHDOG;
                    lvl                  = cfrm_pkg::REMEDY_NONE;
                end
                level_next       = lvl;
                last_remedy_next = item.now_ms;
            end
        end else if (streak_reg != 8'd0) begin
            streak_next = 8'd0;
            level_next  = cfrm_pkg::REMEDY_NONE;
            result.clear_alert = (item.active_alert >= cfrm_pkg::PMIC_ALERT_LO) &&
                                 (item.active_alert <= cfrm_pkg::PMIC_ALERT_HI);
        end
        result.fault_run = streak_next;

        // Stuck fast charge: a start stamp of zero means the timer is idle.
        cstat         = item.status_byte[5:4];
        stuck_elapsed = item.now_ms - stuck_start_reg;
        diff          = (item.charge_level > prev_level_reg) ?
                        (item.charge_level - prev_level_reg) :
                        (prev_level_reg - item.charge_level);
        if (cstat == cfrm_pkg::CSTAT_FAST) begin
            if (prev_fast_reg) begin
                if (diff < cfg.soc_tolerance) begin
                    if (stuck_start_reg == 32'd0) begin
                        stuck_start_next = item.now_ms;
                    end else if (stuck_elapsed > cfg.stuck_limit_ms) begin
                        result.stuck_alert = 1'b1;
                    end
                end else begin
                    stuck_start_next = 32'd0;
                end
            end else begin
                stuck_start_next = item.now_ms;
            end
        end else begin
            stuck_start_next = 32'd0;
        end
        prev_fast_next  = (cstat == cfrm_pkg::CSTAT_FAST);
        prev_level_next = item.charge_level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            safe_reg        <= 1'b1;
            streak_reg      <= 8'd0;
            level_reg       <= cfrm_pkg::REMEDY_NONE;
            last_remedy_reg <= 32'd0;
            prev_fast_reg   <= 1'b0;
            prev_level_reg  <= 14'd0;
            stuck_start_reg <= 32'd0;
        end else if (step) begin
            safe_reg        <= safe_next;
            streak_reg      <= streak_next;
            level_reg       <= level_next;
            last_remedy_reg <= last_remedy_next;
            prev_fast_reg   <= prev_fast_next;
            prev_level_reg  <= prev_level_next;
            stuck_start_reg <= stuck_start_next;
        end
    end

endmodule

>>> rtl/core/charger_fault_remediation_monitor.sv
// Top level of the charger fault remediation monitor: input word register,
// result word register and handshakes. Uses cfrm_pkg, cfrm_cfg_regs, cfrm_core.
//
//  Channel   Direction  Carries
//  s_axis    in         one poll word per handshake (tdata, 88 bits)
//  m_axis    out        one result word per poll (tdata, 16 bits)
//  cfg       in         register index and 32-bit write data
//
// Each poll waits in the input register after acceptance, then the decision logic
// writes the result register and the monitor state on the same edge. A new word is
// accepted every cycle while the result side drains. A held result stalls the input
// register; s_tready follows m_tready combinationally.
// Reset (aresetn low, synchronous) empties both registers and restores all state.

module charger_fault_remediation_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fault_byte[7:0], status_byte[15:8], charge_level[29:16], temperature[41:30],
    // now_ms[73:42], active_alert[81:74], zero fill[87:82]
    input  logic [cfrm_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fault_alert[1:0], stuck_alert[2], remedy_action[4:3], charge_allowed[5],
    // clear_alert[6], fault_run[14:7], zero fill[15]
    output logic [cfrm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cfrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfrm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    cfrm_pkg::item_t   item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    cfrm_pkg::result_t result_reg;
    cfrm_pkg::result_t result;
    cfrm_pkg::cfg_t    cfg;
    logic              advance;
    logic              s_take;

    assign cfg_ready = 1'b1;

    cfrm_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cfrm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // The held poll moves on when the result register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_take ? 1'b1 : (in_valid_reg && !advance);
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg <= s_tdata[$bits(cfrm_pkg::item_t)-1:0];
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

endmodule

>>> rtl/core/cfrm_checker.sv
// Port-level checks for the charger fault remediation monitor, bound to the top level.
// Depends on the top level's port list only.

module cfrm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result word stays offered and unchanged.
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word dropped or changed while stalled");

    // The padding bit of the result word is always zero.
    a_out_pad : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] == 1'b0))
        else $error("result padding bit set");

    // A remediation action needs at least two consecutive faults and is never code 3.
    a_action_streak : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[4:3] != 2'd0)) |->
            ((m_tdata[4:3] != 2'd3) && (m_tdata[14:7] >= 8'd2)))
        else $error("remediation action without a fault streak");

    // A clean poll that clears an alert reports no fault and an empty streak.
    a_clear_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6]) |->
            ((m_tdata[14:7] == 8'd0) && (m_tdata[1:0] == 2'd0) && (m_tdata[4:3] == 2'd0)))
        else $error("alert clear on a faulty poll");

endmodule

bind charger_fault_remediation_monitor cfrm_checker u_cfrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
